### src/tta_pkg.sv
// shared types and constants for the temperature threshold alarm
package tta_pkg;

    // default sizing
    localparam int ADC_BITS_DEF      = 12;
    localparam int ENCODER_STEPS_DEF = 200;

    // fixed field widths
    localparam int CFG_W  = 12;
    localparam int CNT_W  = 8;
    localparam int TEMP_W = 16;
    localparam int THR_W  = 14;
    localparam int SMP_W  = 16;

    // configuration bus
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register reset values
    localparam logic [CFG_W-1:0] CAL_LOW_RST  = 12'd1040;
    localparam logic [CFG_W-1:0] CAL_HIGH_RST = 12'd1380;
    localparam logic [CFG_W-1:0] VREF_CAL_RST = 12'd1660;

    // calibration arithmetic constants
    localparam logic [14:0] SPAN_K = 15'd10000;
    localparam logic [12:0] BASE_K = 13'd3000;
    localparam longint unsigned THR_FULL_CENTI = 10000;

    // saturation limits
    localparam int TEMP_POS_LIM = 32767;
    localparam int TEMP_NEG_LIM = 32768;
    localparam logic [TEMP_W-1:0] TEMP_MAX_V = 16'h7FFF;
    localparam logic [TEMP_W-1:0] TEMP_MIN_V = 16'h8000;

    // register map indexes
    typedef enum logic [1:0] {
        REG_CAL_LOW  = 2'd0,
        REG_CAL_HIGH = 2'd1,
        REG_VREF_CAL = 2'd2
    } t_reg_idx;

    // configuration values
    typedef struct packed {
        logic [CFG_W-1:0] cal_low;
        logic [CFG_W-1:0] cal_high;
        logic [CFG_W-1:0] vref_cal;
    } t_cfg;

    // kind of result being emitted
    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_HALT    = 2'd1,
        KIND_RESTART = 2'd2
    } t_kind;

    // controller to datapath commands
    typedef struct packed {
        logic  load_in;
        logic  mul1;
        logic  mul2;
        logic  sum;
        logic  div_start;
        logic  sat;
        logic  emit;
        t_kind kind;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic err;
        logic div_done;
        logic out_free;
    } t_sts;

    // result transaction payload
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [THR_W-1:0]         threshold_centi;
        logic                     breached;
        logic                     alert;
        logic                     buzzer_en;
        logic                     stopped;
        logic                     reset_request;
        logic [SMP_W-1:0]         sample_number;
        logic                     sensor_error;
    } t_res;

endpackage

### src/tta_if.sv
// sample and result channel interfaces
interface tta_in_if #(
    parameter int ADC_BITS = tta_pkg::ADC_BITS_DEF
);
    import tta_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] sensor_raw;
    logic [ADC_BITS-1:0] vref_conv;
    logic [CNT_W-1:0]    encoder_count;
    logic                button_pressed;

    modport source (output valid, sensor_raw, vref_conv, encoder_count, button_pressed,
                    input ready);
    modport sink   (input valid, sensor_raw, vref_conv, encoder_count, button_pressed,
                    output ready);
endinterface

interface tta_out_if;
    import tta_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_centi;
    logic [THR_W-1:0]         threshold_centi;
    logic                     breached;
    logic                     alert;
    logic                     buzzer_en;
    logic                     stopped;
    logic                     reset_request;
    logic [SMP_W-1:0]         sample_number;
    logic                     sensor_error;

    modport source (output valid, temp_centi, threshold_centi, breached, alert, buzzer_en,
                    stopped, reset_request, sample_number, sensor_error,
                    input ready);
    modport sink   (input valid, temp_centi, threshold_centi, breached, alert, buzzer_en,
                    stopped, reset_request, sample_number, sensor_error,
                    output ready);
endinterface

### src/tta_regs.sv
// calibration register file on the apb-style configuration port
module tta_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tta_pkg::APB_AW-1:0] paddr,
    input  logic [tta_pkg::APB_DW-1:0] pwdata,
    output logic [tta_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output tta_pkg::t_cfg             o_cfg
);
    import tta_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_low  <= CAL_LOW_RST;
            r_cfg.cal_high <= CAL_HIGH_RST;
            r_cfg.vref_cal <= VREF_CAL_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CAL_LOW:  r_cfg.cal_low  <= pwdata[CFG_W-1:0];
                REG_CAL_HIGH: r_cfg.cal_high <= pwdata[CFG_W-1:0];
                REG_VREF_CAL: r_cfg.vref_cal <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_CAL_LOW:  prdata = APB_DW'(r_cfg.cal_low);
            REG_CAL_HIGH: prdata = APB_DW'(r_cfg.cal_high);
            REG_VREF_CAL: prdata = APB_DW'(r_cfg.vref_cal);
            default:      prdata = '0;
        endcase
    end

endmodule

### src/tta_div.sv
// restoring serial divider, one quotient bit per cycle
module tta_div #(
    parameter int NW = 40,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);
    import tta_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // trial subtraction
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

endmodule

### src/tta_ctrl.sv
// sequencing controller and run mode tracking
module tta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_press,
    output logic          o_in_ready,
    input  tta_pkg::t_sts i_sts,
    output tta_pkg::t_cmd o_cmd
);
    import tta_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_DIVS,
        ST_DIVW,
        ST_SAT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_RUN      = 2'd0,
        MODE_HELD     = 2'd1,
        MODE_RELEASED = 2'd2
    } t_mode;

    t_state r_state;
    t_mode  r_mode;
    t_kind  r_kind;
    logic   w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // command decode
    always_comb begin
        o_cmd.load_in   = w_acc;
        o_cmd.mul1      = (r_state == ST_MUL1);
        o_cmd.mul2      = (r_state == ST_MUL2);
        o_cmd.sum       = (r_state == ST_SUM);
        o_cmd.div_start = (r_state == ST_DIVS);
        o_cmd.sat       = (r_state == ST_SAT);
        o_cmd.emit      = (r_state == ST_EMIT) && i_sts.out_free;
        o_cmd.kind      = r_kind;
    end

    // state, run mode and result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_RUN;
            r_kind  <= KIND_RUN;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        case (r_mode)
                            MODE_RUN: begin
                                if (i_press) begin
                                    r_mode  <= MODE_HELD;
                                    r_kind  <= KIND_HALT;
                                    r_state <= ST_EMIT;
                                end else begin
                                    r_kind  <= KIND_RUN;
                                    r_state <= ST_MUL1;
                                end
                            end
                            MODE_HELD: begin
                                if (!i_press) begin
                                    r_mode <= MODE_RELEASED;
                                end
                                r_kind  <= KIND_HALT;
                                r_state <= ST_EMIT;
                            end
                            // released, and the unused code behaves the same
                            default: begin
                                if (i_press) begin
                                    r_mode <= MODE_RUN;
                                    r_kind <= KIND_RESTART;
                                end else begin
                                    r_kind <= KIND_HALT;
                                end
                                r_state <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_MUL1: r_state <= i_sts.err ? ST_EMIT : ST_MUL2;
                ST_MUL2: r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_DIVS;
                ST_DIVS: r_state <= ST_DIVW;
                ST_DIVW: begin
                    if (i_sts.div_done) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT:  r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/tta_dp.sv
// calibration arithmetic, threshold lookup, alarm state and result register
module tta_dp #(
    parameter int ADC_BITS      = tta_pkg::ADC_BITS_DEF,
    parameter int ENCODER_STEPS = tta_pkg::ENCODER_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tta_pkg::t_cfg             i_cfg,
    input  tta_pkg::t_cmd             i_cmd,
    input  logic [ADC_BITS-1:0]       i_sensor,
    input  logic [ADC_BITS-1:0]       i_vref,
    input  logic [tta_pkg::CNT_W-1:0] i_count,
    input  logic                      i_out_ready,
    output tta_pkg::t_sts             o_sts,
    output logic                      o_out_valid,
    output tta_pkg::t_res             o_res
);
    import tta_pkg::*;

    localparam int AW = ADC_BITS;
    localparam int PW = 2 * AW;
    localparam int NW = PW + 16;
    localparam int DW = PW;

    // sampled inputs
    logic [AW-1:0]    r_sensor;
    logic [AW-1:0]    r_vref;
    logic [CNT_W-1:0] r_count;

    // arithmetic pipeline registers
    logic [PW-1:0]        r_p_sv;
    logic [PW-1:0]        r_p_cr;
    logic signed [PW:0]   r_p_rd;
    logic signed [NW-1:0] r_a;
    logic signed [NW-1:0] r_b;
    logic signed [NW-1:0] r_num;
    logic                 r_neg;
    logic [TEMP_W-1:0]    r_temp;

    // alarm state and result register
    logic             r_alert;
    logic [SMP_W-1:0] r_smp;
    logic             r_out_valid;
    t_res             r_res;

    logic [AW-1:0]        w_c1;
    logic [AW-1:0]        w_c2;
    logic [AW-1:0]        w_v;
    logic signed [AW:0]   w_d;
    logic signed [PW:0]   w_rd;
    logic signed [PW:0]   w_diff;
    logic [NW-1:0]        w_num_mag;
    logic [DW-1:0]        w_den_mag;
    logic [NW-1:0]        w_quo;
    logic                 w_div_done;
    logic                 w_err;
    logic                 w_br;
    logic [THR_W-1:0]     w_thr;
    logic [THR_W-1:0]     w_thr_tab [2**CNT_W];
    logic [SMP_W-1:0]     w_smp_inc;

    // threshold table, count saturated to the last encoder step
    for (genvar g = 0; g < 2**CNT_W; g++) begin : g_thr
        localparam longint unsigned SAT_G =
            (g > ENCODER_STEPS - 1) ? longint'(ENCODER_STEPS - 1) : longint'(g);
        localparam longint unsigned VAL = SAT_G * THR_FULL_CENTI / (ENCODER_STEPS - 1);
        assign w_thr_tab[g] = THR_W'(VAL);
    end
    assign w_thr = w_thr_tab[r_count];

    // calibration values at adc width
    assign w_c1 = AW'({{AW{1'b0}}, i_cfg.cal_low});
    assign w_c2 = AW'({{AW{1'b0}}, i_cfg.cal_high});
    assign w_v  = AW'({{AW{1'b0}}, i_cfg.vref_cal});
    assign w_d  = $signed({1'b0, w_c2}) - $signed({1'b0, w_c1});
    assign w_rd = (PW+1)'($signed({1'b0, r_vref})) * (PW+1)'(w_d);

    assign w_err = (r_vref == '0) || (w_c1 == w_c2);

    // numerator difference for the span multiply
    assign w_diff = $signed({1'b0, r_p_sv}) - $signed({1'b0, r_p_cr});

    // magnitudes for the unsigned divider
    assign w_num_mag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign w_den_mag = r_p_rd[PW] ? DW'(-r_p_rd) : DW'(r_p_rd);

    assign w_br      = !w_err &&
                       ($signed(r_temp) >= $signed({{(TEMP_W-THR_W){1'b0}}, w_thr}));
    assign w_smp_inc = r_smp + SMP_W'(1);

    tta_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_num_mag),
        .i_divisor  (w_den_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sensor <= i_sensor;
            r_vref   <= i_vref;
            r_count  <= i_count;
        end
    end

    // product stages, sum and sign
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p_sv <= PW'(r_sensor) * PW'(w_v);
            r_p_cr <= PW'(w_c1) * PW'(r_vref);
            r_p_rd <= w_rd;
        end
        if (i_cmd.mul2) begin
            r_a <= NW'(w_diff) * NW'($signed(SPAN_K));
            r_b <= NW'(r_p_rd) * NW'($signed(BASE_K));
        end
        if (i_cmd.sum) begin
            r_num <= r_a + r_b;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_num[NW-1] ^ r_p_rd[PW];
        end
    end

    // sign restore and saturation of the quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.sat) begin
            if (r_neg) begin
                r_temp <= (w_quo > NW'(TEMP_NEG_LIM)) ? TEMP_MIN_V : -w_quo[TEMP_W-1:0];
            end else begin
                r_temp <= (w_quo > NW'(TEMP_POS_LIM)) ? TEMP_MAX_V : w_quo[TEMP_W-1:0];
            end
        end
    end

    // alert latch, sample counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert     <= 1'b0;
            r_smp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                case (i_cmd.kind)
                    KIND_RUN: begin
                        r_smp <= w_smp_inc;
                        if (w_br) begin
                            r_alert <= 1'b1;
                        end
                    end
                    KIND_RESTART: begin
                        r_smp   <= '0;
                        r_alert <= 1'b0;
                    end
                    default: ;
                endcase
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.kind)
                KIND_RUN: begin
                    r_res.temp_centi      <= w_err ? '0 : $signed(r_temp);
                    r_res.threshold_centi <= w_thr;
                    r_res.breached        <= w_br;
                    r_res.alert           <= r_alert | w_br;
                    r_res.buzzer_en       <= w_br;
                    r_res.stopped         <= 1'b0;
                    r_res.reset_request   <= 1'b0;
                    r_res.sample_number   <= w_smp_inc;
                    r_res.sensor_error    <= w_err;
                end
                KIND_RESTART: begin
                    r_res.temp_centi      <= '0;
                    r_res.threshold_centi <= '0;
                    r_res.breached        <= 1'b0;
                    r_res.alert           <= 1'b0;
                    r_res.buzzer_en       <= 1'b0;
                    r_res.stopped         <= 1'b1;
                    r_res.reset_request   <= 1'b1;
                    r_res.sample_number   <= '0;
                    r_res.sensor_error    <= 1'b0;
                end
                default: begin
                    r_res.temp_centi      <= '0;
                    r_res.threshold_centi <= '0;
                    r_res.breached        <= 1'b0;
                    r_res.alert           <= r_alert;
                    r_res.buzzer_en       <= 1'b0;
                    r_res.stopped         <= 1'b1;
                    r_res.reset_request   <= 1'b0;
                    r_res.sample_number   <= r_smp;
                    r_res.sensor_error    <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.err      = w_err;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_res          = r_res;

endmodule

### src/temperature_threshold_alarm.sv
// temperature threshold alarm top level
// running sample: accepted, multiplied, summed, divided by the serial divider, one quotient
// bit per cycle, saturated and emitted once the output register is free; no new sample is
// accepted before then. calibration error samples jump from the first multiply to emit,
// halted samples straight to emit. a finished result waits in the output register while
// the next sample is accepted. synchronous active-low reset clears run mode, alert, sample
// count and output valid, and loads the calibration registers with their factory values.
module temperature_threshold_alarm #(
    parameter int ADC_BITS      = tta_pkg::ADC_BITS_DEF,
    parameter int ENCODER_STEPS = tta_pkg::ENCODER_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tta_in_if.sink                     i_in,
    tta_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tta_pkg::APB_AW-1:0] paddr,
    input  logic [tta_pkg::APB_DW-1:0] pwdata,
    output logic [tta_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import tta_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    t_res w_res;
    logic w_ready;
    logic w_out_valid;

    tta_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_press    (i_in.button_pressed),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tta_dp #(
        .ADC_BITS      (ADC_BITS),
        .ENCODER_STEPS (ENCODER_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_sensor    (i_in.sensor_raw),
        .i_vref      (i_in.vref_conv),
        .i_count     (i_in.encoder_count),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_res       (w_res)
    );

    // channel hookup
    assign i_in.ready            = w_ready;
    assign o_out.valid           = w_out_valid;
    assign o_out.temp_centi      = w_res.temp_centi;
    assign o_out.threshold_centi = w_res.threshold_centi;
    assign o_out.breached        = w_res.breached;
    assign o_out.alert           = w_res.alert;
    assign o_out.buzzer_en       = w_res.buzzer_en;
    assign o_out.stopped         = w_res.stopped;
    assign o_out.reset_request   = w_res.reset_request;
    assign o_out.sample_number   = w_res.sample_number;
    assign o_out.sensor_error    = w_res.sensor_error;

endmodule

### src/tta_checker.sv
// port-level assertions for the temperature threshold alarm, with bind
module tta_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tta_pkg::TEMP_W-1:0] i_temp,
    input logic                       i_breached,
    input logic                       i_alert,
    input logic                       i_buzzer,
    input logic                       i_stopped,
    input logic                       i_reset_request,
    input logic [tta_pkg::SMP_W-1:0]  i_sample,
    input logic                       i_sensor_error
);
    import tta_pkg::*;

    // one sample in flight: acceptance drops ready for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while a sample was in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_temp) && $stable(i_sample)))
        else $error("stalled result changed");

    // a breach only comes from a good running sample and sets the alert
    a_breach_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_breached) |->
            (i_alert && i_buzzer && !i_stopped && !i_sensor_error))
        else $error("breach without alert or from a halted or bad sample");

    // restart result shows cleared state
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_reset_request) |->
            (i_stopped && !i_alert && i_sample == '0))
        else $error("restart result does not show cleared state");

endmodule

bind temperature_threshold_alarm tta_checker u_tta_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_temp          (o_out.temp_centi),
    .i_breached      (o_out.breached),
    .i_alert         (o_out.alert),
    .i_buzzer        (o_out.buzzer_en),
    .i_stopped       (o_out.stopped),
    .i_reset_request (o_out.reset_request),
    .i_sample        (o_out.sample_number),
    .i_sensor_error  (o_out.sensor_error)
);

### verif/tta_result_check.sv
// result checker for the temperature threshold alarm: predicts and compares each result
`timescale 1ns / 100ps
module tta_result_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tta_in_if                          i_in,
    tta_out_if                         i_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tta_pkg::APB_AW-1:0] paddr,
    input  logic [tta_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         o_err_count,
    output logic                       o_idle
);
    import tta_pkg::*;

    localparam int PRINT_MAX = 50;

    // button state of the alarm
    typedef enum logic [1:0] {
        MODE_RUN      = 2'd0,
        MODE_HELD     = 2'd1,
        MODE_RELEASED = 2'd2
    } t_mode;

    t_cfg             cfg_q;
    logic             alert_q;
    t_mode            mode_q;
    logic [SMP_W-1:0] samples_q;
    t_res             expected_q[$];
    int               err_count = 0;

    assign o_err_count = err_count;

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_MAX) $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    // expected result of one sample, advancing the alarm state
    function automatic t_res predict_result(input logic [ADC_BITS_DEF-1:0] sensor,
                                            input logic [ADC_BITS_DEF-1:0] vref,
                                            input logic [CNT_W-1:0] count,
                                            input logic press);
        t_res              res;
        longint            s, r, c1, c2, v, d, num, den, q;
        longint unsigned   cnt;
        logic [THR_W-1:0]  thr;
        res = '0;
        if (mode_q == MODE_HELD) begin
            if (!press) mode_q = MODE_RELEASED;
        end else if (mode_q != MODE_RUN) begin
            // second press clears everything but the registers
            if (press) begin
                alert_q           = 1'b0;
                mode_q            = MODE_RUN;
                samples_q         = '0;
                res.reset_request = 1'b1;
            end
        end else if (press) begin
            mode_q = MODE_HELD;
        end else begin
            cnt = longint'(count);
            if (cnt > ENCODER_STEPS_DEF - 1) cnt = ENCODER_STEPS_DEF - 1;
            thr = THR_W'((cnt * THR_FULL_CENTI) / (ENCODER_STEPS_DEF - 1));
            res.threshold_centi = thr;
            samples_q = samples_q + 1'b1;
            s  = longint'(sensor);
            r  = longint'(vref);
            c1 = longint'(cfg_q.cal_low);
            c2 = longint'(cfg_q.cal_high);
            v  = longint'(cfg_q.vref_cal);
            d  = c2 - c1;
            if (r == 0 || d == 0) begin
                res.sensor_error = 1'b1;
            end else begin
                // supply-corrected two-point calibration in hundredths
                num = (s * v - c1 * r) * 10000 + 3000 * r * d;
                den = r * d;
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                q = num / den;
                if (q > TEMP_POS_LIM) q = TEMP_POS_LIM;
                if (q < -TEMP_NEG_LIM) q = -TEMP_NEG_LIM;
                res.temp_centi = q[TEMP_W-1:0];
                if (q >= longint'(thr)) begin
                    res.breached = 1'b1;
                    alert_q      = 1'b1;
                end
            end
        end
        res.alert         = alert_q;
        res.buzzer_en     = alert_q & res.breached;
        res.stopped       = (mode_q != MODE_RUN) || res.reset_request;
        res.sample_number = samples_q;
        return res;
    endfunction

    // field by field compare of the accepted result
    task automatic compare_result(input t_res want);
        if (i_out.temp_centi !== want.temp_centi)
            report_mismatch($sformatf("temp_centi got %0d want %0d",
                                      i_out.temp_centi, want.temp_centi));
        if (i_out.threshold_centi !== want.threshold_centi)
            report_mismatch($sformatf("threshold_centi got %0d want %0d",
                                      i_out.threshold_centi, want.threshold_centi));
        if (i_out.breached !== want.breached)
            report_mismatch($sformatf("breached got %b want %b", i_out.breached, want.breached));
        if (i_out.alert !== want.alert)
            report_mismatch($sformatf("alert got %b want %b", i_out.alert, want.alert));
        if (i_out.buzzer_en !== want.buzzer_en)
            report_mismatch($sformatf("buzzer_en got %b want %b",
                                      i_out.buzzer_en, want.buzzer_en));
        if (i_out.stopped !== want.stopped)
            report_mismatch($sformatf("stopped got %b want %b", i_out.stopped, want.stopped));
        if (i_out.reset_request !== want.reset_request)
            report_mismatch($sformatf("reset_request got %b want %b",
                                      i_out.reset_request, want.reset_request));
        if (i_out.sample_number !== want.sample_number)
            report_mismatch($sformatf("sample_number got %0d want %0d",
                                      i_out.sample_number, want.sample_number));
        if (i_out.sensor_error !== want.sensor_error)
            report_mismatch($sformatf("sensor_error got %b want %b",
                                      i_out.sensor_error, want.sensor_error));
    endtask

    // watch registers, samples and results at each edge
    always @(posedge i_clk) begin : watch
        if (!i_rst_n) begin
            cfg_q     = '{cal_low: CAL_LOW_RST, cal_high: CAL_HIGH_RST, vref_cal: VREF_CAL_RST};
            alert_q   = 1'b0;
            mode_q    = MODE_RUN;
            samples_q = '0;
            expected_q.delete();
            o_idle <= 1'b1;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_CAL_LOW:  cfg_q.cal_low  = pwdata[CFG_W-1:0];
                    REG_CAL_HIGH: cfg_q.cal_high = pwdata[CFG_W-1:0];
                    REG_VREF_CAL: cfg_q.vref_cal = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) report_mismatch("result with nothing expected");
                else compare_result(expected_q.pop_front());
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(predict_result(i_in.sensor_raw, i_in.vref_conv,
                                                    i_in.encoder_count, i_in.button_pressed));
            o_idle <= (expected_q.size() == 0);
        end
    end

endmodule

### verif/tb_temperature_threshold_alarm.sv
// testbench top for the temperature threshold alarm: stimulus, register setup and verdict
`timescale 1ns / 100ps
module tb_temperature_threshold_alarm;
    import tta_pkg::*;

    localparam int STALL_MAX      = 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                err_count;
    logic              all_seen;
    bit                in_quiet = 1'b0;
    bit                out_quiet = 1'b0;
    int                idle_cycles = 0;
    logic [CFG_W-1:0]  cal_lo = CAL_LOW_RST;
    logic [CFG_W-1:0]  cal_hi = CAL_HIGH_RST;
    logic [CFG_W-1:0]  vref_c = VREF_CAL_RST;

    tta_in_if  in_ch ();
    tta_out_if out_ch ();

    temperature_threshold_alarm dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tta_result_check result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_err_count (err_count),
        .o_idle      (all_seen)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, STALL_MAX));
    endfunction

    function automatic logic [ADC_BITS_DEF-1:0] clamp_adc(input int x);
        if (x < 0) return '0;
        if (x > 4095) return 12'd4095;
        return 12'(x);
    endfunction

    // result side: random stall before each transaction
    initial begin : result_sink
        int gap;
        forever begin
            gap = pick_gap(out_quiet);
            if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    // one sample transaction after a random gap
    task automatic send_sample(input logic [ADC_BITS_DEF-1:0] sensor,
                               input logic [ADC_BITS_DEF-1:0] vref,
                               input logic [CNT_W-1:0] count, input logic press);
        int gap;
        gap = pick_gap(in_quiet);
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.sensor_raw     <= sensor;
        in_ch.vref_conv      <= vref;
        in_ch.encoder_count  <= count;
        in_ch.button_pressed <= press;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // stop sending and wait for every expected result
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (all_seen !== 1'b1);
    endtask

    // register write: setup then access
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAL_LOW:  cal_lo = value;
            REG_CAL_HIGH: cal_hi = value;
            REG_VREF_CAL: vref_c = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [CFG_W-1:0] vr);
        settle();
        write_reg(REG_CAL_LOW, lo);
        write_reg(REG_CAL_HIGH, hi);
        write_reg(REG_VREF_CAL, vr);
    endtask

    // random samples, mostly near the calibrated range, with press sequences mixed in
    task automatic run_random(input int n);
        int                      sent;
        int                      lo_b;
        int                      hi_b;
        bit                      press_plan[$];
        logic [ADC_BITS_DEF-1:0] s;
        logic [ADC_BITS_DEF-1:0] r;
        logic [CNT_W-1:0]        cnt;
        logic                    btn;
        sent = 0;
        while (sent < n) begin
            // halt, release, restart
            if (press_plan.size() == 0 && $urandom_range(0, 29) == 0) begin
                repeat ($urandom_range(1, 3)) press_plan.push_back(1'b1);
                repeat ($urandom_range(1, 4)) press_plan.push_back(1'b0);
                press_plan.push_back(1'b1);
            end
            if (press_plan.size() != 0) btn = press_plan.pop_front();
            else btn = ($urandom_range(0, 199) == 0);
            if ($urandom_range(0, 9) < 6) begin
                lo_b = int'(cal_lo < cal_hi ? cal_lo : cal_hi) - 150;
                hi_b = int'(cal_lo < cal_hi ? cal_hi : cal_lo) + 150;
                s = 12'($urandom_range(clamp_adc(lo_b), clamp_adc(hi_b)));
                r = clamp_adc(int'(vref_c) + int'($urandom_range(0, 80)) - 40);
            end else begin
                s = 12'($urandom);
                r = 12'($urandom);
            end
            cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 199));
            send_sample(s, r, cnt, btn);
            if (!btn) sent++;
        end
    endtask

    // main sequence
    initial begin : stimulus
        logic [CFG_W-1:0] lo;
        in_ch.valid          <= 1'b0;
        in_ch.sensor_raw     <= '0;
        in_ch.vref_conv      <= '0;
        in_ch.encoder_count  <= '0;
        in_ch.button_pressed <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, factory calibration
        send_sample(12'd0, 12'd0, 8'd0, 1'b0);        // zero reference
        send_sample(12'd1040, 12'd1660, 8'd60, 1'b0); // 30.00 just under threshold
        send_sample(12'd0, 12'd4095, 8'd0, 1'b0);     // cold reading
        send_sample(12'd4095, 12'd4095, 8'd200, 1'b0); // count saturates, breach
        send_sample(12'd1040, 12'd1660, 8'd60, 1'b0); // alert stays, no buzzer
        send_sample(12'd938, 12'd1660, 8'd0, 1'b0);   // temperature equals threshold
        send_sample(12'd4095, 12'd1, 8'd255, 1'b0);   // positive saturation
        send_sample(12'd2000, 12'd0, 8'd100, 1'b0);   // error with alert set
        send_sample(12'd1040, 12'd1660, 8'd199, 1'b1); // first press halts
        send_sample(12'd4095, 12'd4095, 8'd0, 1'b1);  // still held
        send_sample(12'd1040, 12'd1660, 8'd0, 1'b0);  // release
        send_sample(12'd1040, 12'd1660, 8'd0, 1'b0);  // halted
        send_sample(12'd1040, 12'd1660, 8'd0, 1'b1);  // second press restarts
        send_sample(12'd1040, 12'd1660, 8'd0, 1'b1);  // held across restart halts again
        send_sample(12'd1040, 12'd1660, 8'd0, 1'b0);
        send_sample(12'd1040, 12'd1660, 8'd0, 1'b1);
        send_sample(12'd1040, 12'd1660, 8'd59, 1'b0); // running again, breach

        run_random(250);

        // realistic factory values
        lo = 12'($urandom_range(800, 1200));
        configure(lo, lo + 12'($urandom_range(200, 600)), 12'($urandom_range(1400, 1900)));
        run_random(250);

        // reversed span at the extremes
        configure(12'd4095, 12'd0, 12'd4095);
        run_random(150);

        configure(12'd0, 12'd4095, 12'd0);
        run_random(150);

        // equal calibration points
        lo = 12'($urandom);
        configure(lo, lo, 12'($urandom));
        run_random(100);

        configure(12'($urandom), 12'($urandom), 12'($urandom));
        run_random(150);

        // back to factory values
        configure(CAL_LOW_RST, CAL_HIGH_RST, VREF_CAL_RST);
        run_random(30);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
